// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file.
// Depends on nothing; expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define TFFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define TFFD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/tffd_pkg.sv -----
// Types, constants and helpers of the frame deframer/filter.
// Used by every module of the block; depends on nothing.
package tffd_pkg;

  localparam int ZONES_DEF     = 16;
  localparam int OUT_DEPTH_DEF = 4;
  localparam int ZONE_IDX_W    = 6;   // wide enough for the largest zone count
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;

  localparam logic [7:0]         SYNC_RST      = 8'h00;
  localparam logic signed [15:0] LIMIT_RST     = 16'sh7FFF;
  localparam logic signed [15:0] INVALID_DIST  = 16'shFFFF;

  localparam logic [7:0] STATUS_OK_A = 8'd5;
  localparam logic [7:0] STATUS_OK_B = 8'd6;
  localparam logic [7:0] STATUS_OK_C = 8'd9;
  localparam logic [7:0] STATUS_OK_D = 8'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC_FIRST  = 2'd0,
    CFG_SYNC_SECOND = 2'd1,
    CFG_DIST_LIMIT  = 2'd2,
    CFG_LIMIT_REPL  = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PS_HUNT,
    PS_ID,
    PS_DIST,
    PS_STAT
  } parse_state_t;

  // Zone store write from the parser
  typedef struct packed {
    logic                  dist_we;
    logic                  stat_we;
    logic                  bank;
    logic [ZONE_IDX_W-1:0] zone;
    logic [15:0]           data;
  } store_wr_t;

  // One finished frame waiting for the emitter
  typedef struct packed {
    logic [7:0] id;
    logic       bank;
  } frame_desc_t;

  typedef struct packed {
    logic [7:0]         src_id;
    logic [3:0]         zone_index;
    logic signed [15:0] distance;
    logic [7:0]         status;
    logic               last;
  } result_t;

  function automatic logic status_ok(input logic [7:0] s);
    return s inside {STATUS_OK_A, STATUS_OK_B, STATUS_OK_C, STATUS_OK_D};
  endfunction

endpackage

// ----- rtl/core/tffd_front.sv -----
// Byte parser: header hunt, id, distances and status bytes into the zone store.
// Depends on tffd_pkg; hands finished frames to tffd_frame_queue.
module tffd_front #(
  parameter int ZONES = tffd_pkg::ZONES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  input  logic                   q_full,
  input  logic [7:0]             rx_byte,
  input  logic [7:0]             sync_first,
  input  logic [7:0]             sync_second,
  output tffd_pkg::store_wr_t    st_wr,
  output logic                   desc_push,
  output tffd_pkg::frame_desc_t  desc
);

  localparam int ZW = (ZONES > 1) ? $clog2(ZONES) : 1;
  localparam logic [ZW:0]   DistLast = (ZW+1)'(2*ZONES-1);
  localparam logic [ZW-1:0] StatLast = ZW'(ZONES-1);

  tffd_pkg::parse_state_t state_r, state_nxt;
  logic          prev_valid_r, prev_valid_nxt;
  logic [7:0]    prev_r, prev_nxt;
  logic [7:0]    id_r, id_nxt;
  logic [7:0]    low_r, low_nxt;
  logic [ZW:0]   dcnt_r, dcnt_nxt;
  logic [ZW-1:0] scnt_r, scnt_nxt;
  logic          bank_r, bank_nxt;
  logic          accept;

  assign accept = in_push & ~q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tffd_pkg::PS_HUNT;
      prev_valid_r <= 1'b0;
      prev_r       <= '0;
      id_r         <= '0;
      low_r        <= '0;
      dcnt_r       <= '0;
      scnt_r       <= '0;
      bank_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      prev_valid_r <= prev_valid_nxt;
      prev_r       <= prev_nxt;
      id_r         <= id_nxt;
      low_r        <= low_nxt;
      dcnt_r       <= dcnt_nxt;
      scnt_r       <= scnt_nxt;
      bank_r       <= bank_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    prev_valid_nxt = prev_valid_r;
    prev_nxt       = prev_r;
    id_nxt         = id_r;
    low_nxt        = low_r;
    dcnt_nxt       = dcnt_r;
    scnt_nxt       = scnt_r;
    bank_nxt       = bank_r;
    st_wr          = '0;
    st_wr.bank     = bank_r;
    desc_push      = 1'b0;
    desc.id        = id_r;
    desc.bank      = bank_r;
    if (accept) begin
      case (state_r)
        tffd_pkg::PS_HUNT: begin
          if (prev_valid_r && prev_r == sync_first && rx_byte == sync_second) begin
            state_nxt      = tffd_pkg::PS_ID;
            prev_valid_nxt = 1'b0;
          end else begin
            prev_nxt       = rx_byte;
            prev_valid_nxt = 1'b1;
          end
        end
        tffd_pkg::PS_ID: begin
          id_nxt    = rx_byte;
          dcnt_nxt  = '0;
          state_nxt = tffd_pkg::PS_DIST;
        end
        tffd_pkg::PS_DIST: begin
          // even count: low byte, odd count: high byte completes the distance
          if (!dcnt_r[0]) begin
            low_nxt = rx_byte;
          end else begin
            st_wr.dist_we = 1'b1;
            st_wr.zone    = tffd_pkg::ZONE_IDX_W'(dcnt_r[ZW:1]);
            st_wr.data    = {rx_byte, low_r};
          end
          dcnt_nxt = dcnt_r + 1'b1;
          if (dcnt_r == DistLast) begin
            state_nxt = tffd_pkg::PS_STAT;
            scnt_nxt  = '0;
          end
        end
        tffd_pkg::PS_STAT: begin
          st_wr.stat_we = 1'b1;
          st_wr.zone    = tffd_pkg::ZONE_IDX_W'(scnt_r);
          st_wr.data    = {8'h00, rx_byte};
          if (scnt_r == StatLast) begin
            // frame done: hand it off, switch banks, hunt again
            desc_push      = 1'b1;
            bank_nxt       = ~bank_r;
            state_nxt      = tffd_pkg::PS_HUNT;
            prev_valid_nxt = 1'b0;
            prev_nxt       = '0;
          end else begin
            scnt_nxt = scnt_r + 1'b1;
          end
        end
        default: state_nxt = tffd_pkg::PS_HUNT;
      endcase
    end
  end

endmodule

// ----- rtl/core/tffd_frame_queue.sv -----
// Two-entry queue of finished frames between parser and emitter.
// Depends on tffd_pkg; full means both store banks are held.
module tffd_frame_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  tffd_pkg::frame_desc_t desc_in,
  input  logic                  pop,
  output tffd_pkg::frame_desc_t desc_out,
  output logic                  valid,
  output logic                  full
);

  tffd_pkg::frame_desc_t q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign valid    = (cnt_r != 2'd0);
  assign full     = (cnt_r == 2'd2);
  assign desc_out = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= desc_in;
  end

endmodule

// ----- rtl/core/tffd_out_fifo.sv -----
// Result queue in front of the output ports.
// Depends on tffd_pkg for the result record.
module tffd_out_fifo #(
  parameter int DEPTH = tffd_pkg::OUT_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  input  tffd_pkg::result_t               din,
  input  logic                            pop,
  output tffd_pkg::result_t               dout,
  output logic                            empty,
  output logic [$clog2(DEPTH+1)-1:0]      count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);
  localparam logic [PW-1:0] PtrLast = PW'(DEPTH-1);

  tffd_pkg::result_t mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          take;

  assign empty = (cnt_r == '0);
  assign count = cnt_r;
  assign dout  = mem_r[rp_r];
  assign take  = pop & ~empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PtrLast) ? '0 : wp_r + 1'b1;
      if (take) rp_r <= (rp_r == PtrLast) ? '0 : rp_r + 1'b1;
      case ({push, take})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= din;
  end

endmodule

// ----- rtl/core/tffd_back.sv -----
// Emitter: double-banked zone store, per-zone read and distance filter.
// Depends on tffd_pkg; feeds tffd_out_fifo one result per cycle while a frame waits and the queue has room.
module tffd_back #(
  parameter int ZONES     = tffd_pkg::ZONES_DEF,
  parameter int OUT_DEPTH = tffd_pkg::OUT_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tffd_pkg::store_wr_t               st_wr,
  input  logic                              desc_valid,
  input  tffd_pkg::frame_desc_t             desc,
  input  logic signed [15:0]                dist_limit,
  input  logic signed [15:0]                limit_repl,
  input  logic [$clog2(OUT_DEPTH+1)-1:0]    fifo_count,
  output logic                              desc_pop,
  output logic                              res_push,
  output tffd_pkg::result_t                 res
);

  localparam int ZW = (ZONES > 1) ? $clog2(ZONES) : 1;
  localparam int AW = ZW + 1;
  localparam int CW = $clog2(OUT_DEPTH+1);
  localparam logic [ZW-1:0] ZoneLast = ZW'(ZONES-1);

  logic signed [15:0] dist_mem [2**AW];
  logic [7:0]         stat_mem [2**AW];

  logic               rd_v_r;
  logic [ZW-1:0]      zc_r;
  logic [ZW-1:0]      rd_zone_r;
  logic               rd_last_r;
  logic [7:0]         rd_id_r;
  logic signed [15:0] rd_dist_r;
  logic [7:0]         rd_stat_r;
  logic               issue;
  logic               zone_last;

  // count the read in flight so the queue never overflows
  assign issue     = desc_valid && ((fifo_count + CW'(rd_v_r)) < CW'(OUT_DEPTH));
  assign zone_last = (zc_r == ZoneLast);
  assign desc_pop  = issue & zone_last;

  always_ff @(posedge clk) begin
    if (st_wr.dist_we) dist_mem[{st_wr.bank, st_wr.zone[ZW-1:0]}] <= st_wr.data;
    if (st_wr.stat_we) stat_mem[{st_wr.bank, st_wr.zone[ZW-1:0]}] <= st_wr.data[7:0];
    if (issue) begin
      rd_dist_r <= dist_mem[{desc.bank, zc_r}];
      rd_stat_r <= stat_mem[{desc.bank, zc_r}];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
      zc_r   <= '0;
    end else begin
      rd_v_r <= issue;
      if (issue) zc_r <= zone_last ? '0 : zc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_zone_r <= zc_r;
      rd_last_r <= zone_last;
      rd_id_r   <= desc.id;
    end
  end

  always_comb begin
    res_push       = rd_v_r;
    res.src_id     = rd_id_r;
    res.zone_index = 4'(rd_zone_r);
    res.status     = rd_stat_r;
    res.last       = rd_last_r;
    if (!tffd_pkg::status_ok(rd_stat_r)) begin
      res.distance = tffd_pkg::INVALID_DIST;
    end else if (rd_dist_r > dist_limit) begin
      res.distance = limit_repl;
    end else begin
      res.distance = rd_dist_r;
    end
  end

endmodule

// ----- rtl/core/tof_frame_deframer_filter.sv -----
// Time-of-flight frame deframer and per-zone distance filter, top level.
// Depends on tffd_pkg, tffd_front, tffd_frame_queue, tffd_back, tffd_out_fifo.
//
// Usage:
//  - Input: one received byte per push, taken when full is low. The parser
//    hunts for the two header bytes, then takes an id byte, ZONES little-endian
//    distances and ZONES status bytes.
//  - Output: after the frame's final byte, ZONES results (one per zone, the last
//    marked by frame_last) enter the output queue; take each with pop while
//    empty is low.
//  - Config: cfg_we writes register cfg_index (sync_first, sync_second,
//    distance_limit, limit_replacement) at once; write only while idle.
//  - Throughput: one byte per cycle in while full is low, one result per
//    cycle out while the output queue has room. Each result passes a store
//    read register, then the filter, on its way into the output queue.
//  - Stall: the zone store has two banks; a finished frame holds its bank
//    until its last result leaves the emitter. With two frames waiting, full
//    stays high and no byte is taken until the emitter frees a bank.
//  - Reset (synchronous, rst_n low): parser hunts, queues empty, limits at
//    32767, header bytes at zero.
module tof_frame_deframer_filter #(
  parameter int ZONES     = tffd_pkg::ZONES_DEF,
  parameter int OUT_DEPTH = tffd_pkg::OUT_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  output logic                               in_full,
  input  logic [7:0]                         in_rx_byte,
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic [7:0]                         out_sensor_id,
  output logic [3:0]                         out_zone_index,
  output logic signed [15:0]                 out_distance_out,
  output logic [7:0]                         out_zone_status,
  output logic                               out_frame_last,
  input  logic                               cfg_we,
  input  logic [tffd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tffd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  logic [7:0]         sync_first_r;
  logic [7:0]         sync_second_r;
  logic signed [15:0] dist_limit_r;
  logic signed [15:0] limit_repl_r;

  tffd_pkg::store_wr_t   st_wr;
  tffd_pkg::frame_desc_t desc_in, desc_out;
  tffd_pkg::result_t     res, res_out;
  logic desc_push, desc_pop, desc_valid, q_full, res_push;
  logic [$clog2(OUT_DEPTH+1)-1:0] fifo_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= tffd_pkg::SYNC_RST;
      sync_second_r <= tffd_pkg::SYNC_RST;
      dist_limit_r  <= tffd_pkg::LIMIT_RST;
      limit_repl_r  <= tffd_pkg::LIMIT_RST;
    end else if (cfg_we) begin
      case (tffd_pkg::cfg_reg_t'(cfg_index))
        tffd_pkg::CFG_SYNC_FIRST:  sync_first_r  <= cfg_wdata[7:0];
        tffd_pkg::CFG_SYNC_SECOND: sync_second_r <= cfg_wdata[7:0];
        tffd_pkg::CFG_DIST_LIMIT:  dist_limit_r  <= cfg_wdata;
        tffd_pkg::CFG_LIMIT_REPL:  limit_repl_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_full = q_full;

  tffd_front #(.ZONES(ZONES)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .q_full      (q_full),
    .rx_byte     (in_rx_byte),
    .sync_first  (sync_first_r),
    .sync_second (sync_second_r),
    .st_wr       (st_wr),
    .desc_push   (desc_push),
    .desc        (desc_in)
  );

  tffd_frame_queue u_fq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (desc_push),
    .desc_in  (desc_in),
    .pop      (desc_pop),
    .desc_out (desc_out),
    .valid    (desc_valid),
    .full     (q_full)
  );

  tffd_back #(.ZONES(ZONES), .OUT_DEPTH(OUT_DEPTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .st_wr      (st_wr),
    .desc_valid (desc_valid),
    .desc       (desc_out),
    .dist_limit (dist_limit_r),
    .limit_repl (limit_repl_r),
    .fifo_count (fifo_count),
    .desc_pop   (desc_pop),
    .res_push   (res_push),
    .res        (res)
  );

  tffd_out_fifo #(.DEPTH(OUT_DEPTH)) u_ofifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res),
    .pop   (out_pop),
    .dout  (res_out),
    .empty (out_empty),
    .count (fifo_count)
  );

  assign out_sensor_id    = res_out.src_id;
  assign out_zone_index   = res_out.zone_index;
  assign out_distance_out = res_out.distance;
  assign out_zone_status  = res_out.status;
  assign out_frame_last   = res_out.last;

endmodule

// ----- rtl/core/tffd_checker.sv -----
// Port-level checks of the frame deframer/filter, bound to the top level.
// Depends on assert_macros.svh and tffd_pkg.
`include "assert_macros.svh"

module tffd_checker #(
  parameter int ZONES = tffd_pkg::ZONES_DEF
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_full,
  input logic              out_empty,
  input logic              out_pop,
  input logic [7:0]        out_sensor_id,
  input logic [3:0]        out_zone_index,
  input logic signed [15:0] out_distance_out,
  input logic [7:0]        out_zone_status,
  input logic              out_frame_last
);

  localparam logic [3:0] LastZone = 4'(ZONES-1);

  `TFFD_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> (out_empty && !in_full), "reset left a word or full flag")
  `TFFD_ASSERT(a_hold_stalled, (!out_empty && !out_pop) |=> (!out_empty && $stable(out_sensor_id) && $stable(out_zone_index) && $stable(out_distance_out) && $stable(out_zone_status) && $stable(out_frame_last)), "stalled result word changed")
  `TFFD_ASSERT(a_last_zone, (!out_empty && out_frame_last) |-> (out_zone_index == LastZone), "frame_last not on final zone")
  `TFFD_ASSERT(a_zone_seq, ((!out_empty && out_pop && !out_frame_last) ##1 !out_empty) |-> ((out_sensor_id == $past(out_sensor_id)) && (out_zone_index == 4'($past(out_zone_index) + 4'd1))), "zone results out of sequence")

endmodule

bind tof_frame_deframer_filter tffd_checker #(.ZONES(ZONES)) u_tffd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_full          (in_full),
  .out_empty        (out_empty),
  .out_pop          (out_pop),
  .out_sensor_id    (out_sensor_id),
  .out_zone_index   (out_zone_index),
  .out_distance_out (out_distance_out),
  .out_zone_status  (out_zone_status),
  .out_frame_last   (out_frame_last)
);

// ----- sim/tb_tof_frame_deframer_filter.sv -----
// Self-checking testbench of tof_frame_deframer_filter: feeds framed, cut-short and
// stray bytes, predicts every zone word and checks each one as it is popped.
// Depends on tffd_pkg and the RTL of the block.
module tb_tof_frame_deframer_filter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ZONES        = tffd_pkg::ZONES_DEF;
  localparam int FRAME_BYTES  = 3 + 3 * ZONES;
  localparam int DRAIN_CYCLES = 8;
  localparam int SEG_BYTES    = 50;
  localparam logic [2:0] KEEP_CFG = 3'd7;
  // valid codes, their neighbors and a few far-off values
  localparam logic [0:15][7:0] STATUS_MIX = {8'd0, 8'd5, 8'd4, 8'd6, 8'd7, 8'd9, 8'd8, 8'd10,
                                             8'd11, 8'd255, 8'd5, 8'd1, 8'd10, 8'd128, 8'd6,
                                             8'd9};

  typedef struct packed {
    logic [2:0]         cfg_sel;   // register setting loaded first, KEEP_CFG for none
    logic [1:0]         n_first;   // sync_first bytes ahead of sync_second
    logic [7:0]         id;
    logic [15:0]        base_dist; // zone 0 distance
    logic [15:0]        step;      // added per zone
    logic [7:0]         status;
    logic               stat_mix;  // take STATUS_MIX instead of status
    logic               trap;      // sync_second right after the frame
    logic               typed;     // every word of the frame carries exp_dist
    logic signed [15:0] exp_dist;
  } frame_case_t;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_push    = 1'b0;
  logic [7:0]                     in_rx_byte = 8'h00;
  logic                           out_pop    = 1'b0;
  logic                           cfg_we     = 1'b0;
  logic [tffd_pkg::CFG_IDX_W-1:0] cfg_index  = tffd_pkg::CFG_SYNC_FIRST;
  logic [tffd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                           in_full;
  logic                           out_empty;
  logic [7:0]                     out_sensor_id;
  logic [3:0]                     out_zone_index;
  logic signed [15:0]             out_distance_out;
  logic [7:0]                     out_zone_status;
  logic                           out_frame_last;

  // predictor copy of the registers and of the parser
  logic [7:0]         pred_sync_first  = tffd_pkg::SYNC_RST;
  logic [7:0]         pred_sync_second = tffd_pkg::SYNC_RST;
  logic signed [15:0] pred_limit       = tffd_pkg::LIMIT_RST;
  logic signed [15:0] pred_repl        = tffd_pkg::LIMIT_RST;
  int                 parse_pos        = 0;
  logic [7:0]         hunt_byte        = 8'h00;
  logic               last_valid       = 1'b0;
  logic [7:0]         frame_id         = 8'h00;
  logic [7:0]         dist_low         = 8'h00;
  logic [15:0]        zone_dist [ZONES];
  logic [7:0]         zone_stat [ZONES];

  tffd_pkg::result_t pending_results [$];
  logic        typed_frame   = 1'b0;
  logic        failed        = 1'b0;
  int          push_idle_pct = 22;
  int          pop_idle_pct  = 76;
  int          seg_count;
  logic [15:0] frame_dist [ZONES];
  logic [7:0]  frame_stat [ZONES];
  frame_case_t dir_cases [2];

  tof_frame_deframer_filter dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_rx_byte       (in_rx_byte),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_sensor_id    (out_sensor_id),
    .out_zone_index   (out_zone_index),
    .out_distance_out (out_distance_out),
    .out_zone_status  (out_zone_status),
    .out_frame_last   (out_frame_last),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [15:0] filtered_distance(input logic signed [15:0] d,
                                                           input logic [7:0] s);
    if (!(s == tffd_pkg::STATUS_OK_A || s == tffd_pkg::STATUS_OK_B ||
          s == tffd_pkg::STATUS_OK_C || s == tffd_pkg::STATUS_OK_D))
      return -16'sd1;
    if (d > pred_limit) return pred_repl;
    return d;
  endfunction

  task automatic deframe_byte(input logic [7:0] b);
    int                k;
    tffd_pkg::result_t r;
    if (parse_pos == 0) begin
      if (last_valid && hunt_byte == pred_sync_first && b == pred_sync_second) begin
        parse_pos  = 1;
        last_valid = 1'b0;
      end else begin
        hunt_byte  = b;
        last_valid = 1'b1;
      end
    end else if (parse_pos == 1) begin
      frame_id  = b;
      parse_pos = 2;
    end else begin
      k = parse_pos - 2;
      parse_pos++;
      if (k < 2 * ZONES) begin
        if (k % 2 == 0) dist_low = b;
        else zone_dist[k / 2] = {b, dist_low};
      end else begin
        zone_stat[k - 2 * ZONES] = b;
        if (k - 2 * ZONES == ZONES - 1) begin
          for (int z = 0; z < ZONES; z++) begin
            r.src_id     = frame_id;
            r.zone_index = 4'(z);
            r.distance   = filtered_distance(zone_dist[z], zone_stat[z]);
            r.status     = zone_stat[z];
            r.last       = (z == ZONES - 1);
            if (!typed_frame) pending_results.insert(pending_results.size(), r);
          end
          // back to hunting: a new header needs two fresh bytes
          parse_pos  = 0;
          last_valid = 1'b0;
          hunt_byte  = 8'h00;
        end
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    while ($urandom_range(99) < push_idle_pct) gap++;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push    <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_full);
    deframe_byte(b);
  endtask

  task automatic send_frame(input int n_first, input logic [7:0] id);
    repeat (n_first) send_byte(pred_sync_first);
    send_byte(pred_sync_second);
    send_byte(id);
    for (int z = 0; z < ZONES; z++) begin
      send_byte(frame_dist[z][7:0]);
      send_byte(frame_dist[z][15:8]);
    end
    for (int z = 0; z < ZONES; z++) send_byte(frame_stat[z]);
  endtask

  // Write all four registers once the block has drained.
  task automatic program_regs(input logic [7:0] sf, input logic [7:0] ss,
                              input logic [15:0] lim, input logic [15:0] repl);
    in_push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= tffd_pkg::CFG_SYNC_FIRST;
    cfg_wdata <= {8'h00, sf};
    @(posedge clk);
    pred_sync_first = sf;
    cfg_index <= tffd_pkg::CFG_SYNC_SECOND;
    cfg_wdata <= {8'h00, ss};
    @(posedge clk);
    pred_sync_second = ss;
    cfg_index <= tffd_pkg::CFG_DIST_LIMIT;
    cfg_wdata <= lim;
    @(posedge clk);
    pred_limit = lim;
    cfg_index <= tffd_pkg::CFG_LIMIT_REPL;
    cfg_wdata <= repl;
    @(posedge clk);
    pred_repl = repl;
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_extreme();
    case ($urandom_range(3))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_distance();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return pred_limit;
      3: return pred_limit + 16'sd1;
      4: return pred_limit - 16'sd1;
      5: return ($urandom_range(1) == 0) ? 16'h0000 : 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_status();
    case ($urandom_range(9))
      0, 1: return tffd_pkg::STATUS_OK_A;
      2, 3: return tffd_pkg::STATUS_OK_B;
      4: return tffd_pkg::STATUS_OK_C;
      5: return tffd_pkg::STATUS_OK_D;
      6: return STATUS_MIX[$urandom_range(15)];
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_random_traffic();
    int kind;
    int len;
    kind = $urandom_range(99);
    if (kind < 75) begin
      for (int z = 0; z < ZONES; z++) begin
        frame_dist[z] = pick_distance();
        frame_stat[z] = pick_status();
      end
      send_frame((pred_sync_first == pred_sync_second) ? 1 : $urandom_range(3, 1),
                 8'($urandom));
      seg_count += FRAME_BYTES;
    end else if (kind < 90) begin
      // stray bytes, often the first header byte
      len = $urandom_range(6, 1);
      repeat (len) send_byte(($urandom_range(2) == 0) ? pred_sync_first : 8'($urandom));
    end else begin
      // cut a frame short; whatever follows is taken as its data
      len = $urandom_range(2 * ZONES);
      send_byte(pred_sync_first);
      send_byte(pred_sync_second);
      send_byte(8'($urandom));
      repeat (len) send_byte(8'($urandom));
      seg_count += len + 3;
    end
  endtask

  always @(posedge clk) begin : pop_side
    tffd_pkg::result_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_results.size() == 0) begin
        $error("unexpected word: out_sensor_id %0h zone_index %0d", out_sensor_id,
               out_zone_index);
        failed = 1'b1;
      end else begin
        want = pending_results.pop_front();
        if (out_sensor_id !== want.src_id) begin
          $error("out_sensor_id: expected %0h, got %0h", want.src_id, out_sensor_id);
          failed = 1'b1;
        end
        if (out_zone_index !== want.zone_index) begin
          $error("zone_index: expected %0d, got %0d", want.zone_index, out_zone_index);
          failed = 1'b1;
        end
        if (out_distance_out !== want.distance) begin
          $error("distance_out: expected %0d, got %0d", want.distance, out_distance_out);
          failed = 1'b1;
        end
        if (out_zone_status !== want.status) begin
          $error("zone_status: expected %0d, got %0d", want.status, out_zone_status);
          failed = 1'b1;
        end
        if (out_frame_last !== want.last) begin
          $error("frame_last: expected %0b, got %0b", want.last, out_frame_last);
          failed = 1'b1;
        end
      end
    end
    out_pop <= ($urandom_range(99) >= pop_idle_pct);
  end

  initial begin
    frame_case_t       c;
    tffd_pkg::result_t r;
    dir_cases = '{
      // reset registers: header 00 00, limit 32767
      '{KEEP_CFG, 2'd1, 8'h00, 16'h7FFF, 16'h0000, 8'd5,  1'b0, 1'b0, 1'b1, 16'sh7FFF},
      // run of first header bytes; frame ends on sync_first, then sync_second
      // must not open a frame
      '{3'd2,     2'd3, 8'h7E, 16'h0001, 16'h0000, 8'd9,  1'b0, 1'b1, 1'b1, 16'sh8000}
    };
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_cases[i]) begin
      c = dir_cases[i];
      case (c.cfg_sel)
        3'd0: program_regs(8'h5A, 8'hA5, 16'd1000, 16'h1234);
        3'd1: program_regs(8'hFF, 8'h00, 16'h8000, 16'h7FFF);
        3'd2: program_regs(8'h09, 8'h0A, 16'h0000, 16'h8000);
        3'd3: program_regs(8'h00, 8'hFF, 16'h7FFF, 16'hFFFF);
        3'd4: program_regs(8'h03, 8'h03, 16'd200, 16'd100);
        default: ;
      endcase
      for (int z = 0; z < ZONES; z++) begin
        frame_dist[z] = c.base_dist + 16'(z) * c.step;
        frame_stat[z] = c.stat_mix ? STATUS_MIX[z] : c.status;
      end
      typed_frame = c.typed;
      send_frame(c.n_first, c.id);
      typed_frame = 1'b0;
      if (c.typed) begin
        for (int z = 0; z < ZONES; z++) begin
          r.src_id     = c.id;
          r.zone_index = 4'(z);
          r.distance   = c.exp_dist;
          r.status     = c.status;
          r.last       = (z == ZONES - 1);
          pending_results.insert(pending_results.size(), r);
        end
      end
      if (c.trap) send_byte(pred_sync_second);
    end

    for (int seg = 0; seg < 3; seg++) begin
      push_idle_pct = (seg == 0) ? 22 : (seg == 1) ? 76 : 0;
      pop_idle_pct  = (seg == 0) ? 76 : (seg == 1) ? 22 : 0;
      program_regs(8'($urandom), ($urandom_range(3) == 0) ? pred_sync_first : 8'($urandom),
                   pick_extreme(), pick_extreme());
      if ($urandom_range(3) == 0) program_regs(pred_sync_first, pred_sync_first,
                                               pick_extreme(), pick_extreme());
      seg_count = 0;
      while (seg_count < SEG_BYTES) send_random_traffic();
      // finish any open frame so the next register write lands while hunting
      while (parse_pos != 0) send_byte(8'($urandom));
    end

    in_push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed && pending_results.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- tof_frame_deframer_filter.f -----
+incdir+rtl/core
rtl/core/tffd_pkg.sv
rtl/core/tffd_front.sv
rtl/core/tffd_frame_queue.sv
rtl/core/tffd_out_fifo.sv
rtl/core/tffd_back.sv
rtl/core/tof_frame_deframer_filter.sv
rtl/core/tffd_checker.sv
sim/tb_tof_frame_deframer_filter.sv
